// ===== rtl/dotp_pkg.sv =====
// Package for the DHCP option TLV parser core: shared constants, codes,
// state types and the controller-to-datapath command and status structs.
// No dependencies.
`timescale 1ns / 1ps

package dotp_pkg;

  localparam int MAX_AREA_DEF = 1024;

  localparam int AREA_W = 11;
  localparam int POS_W = 16;
  localparam int OFF_W = 10;
  localparam int CODE_W = 8;
  localparam int LEN_W = 8;
  localparam int ENTRY_W = OFF_W + LEN_W;
  localparam int TABLE_DEPTH = 256;

  localparam logic [POS_W-1:0] POS_LIMIT = {POS_W{1'b1}};
  localparam logic [CODE_W-1:0] END_CODE = 8'd255;
  localparam logic [1:0] HDR_LEN = 2'd2;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;
  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } ctrl_state_e;

  typedef enum logic {
    PH_CODE,
    PH_LENGTH
  } parse_phase_e;

  typedef struct packed {
    logic byte_step;
    logic lookup_issue;
    logic lookup_finish;
  } dotp_cmd_t;

  typedef struct packed {
    logic out_stall;
  } dotp_status_t;

endpackage

// ===== rtl/dotp_ctrl.sv =====
// Controller of the DHCP option TLV parser: accepts input transfers and
// sequences the lookup through its issue and finish states. Depends on dotp_pkg.
`timescale 1ns / 1ps

module dotp_ctrl
  import dotp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic         mode_i,
  input  dotp_status_t status_i,
  output logic         in_ready_o,
  output dotp_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;
  logic accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (mode_i == MODE_LOOKUP)) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = !status_i.out_stall;
        cmd_o.byte_step = in_valid_i && !status_i.out_stall && (mode_i == MODE_BYTE);
        cmd_o.lookup_issue = in_valid_i && !status_i.out_stall && (mode_i == MODE_LOOKUP);
      end
      ST_LOOKUP: begin
        cmd_o.lookup_finish = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/dotp_datapath.sv =====
// Datapath of the DHCP option TLV parser: byte counters, header parsing,
// the per-code record table and the result register. Depends on dotp_pkg.
`timescale 1ns / 1ps

module dotp_datapath
  import dotp_pkg::*;
#(
  parameter int MAX_AREA = MAX_AREA_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dotp_cmd_t         cmd_i,
  output dotp_status_t      status_o,
  input  logic [7:0]        data_byte_i,
  input  logic              first_byte_i,
  input  logic [AREA_W-1:0] area_length_i,
  input  logic [7:0]        query_code_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              kind_o,
  output logic              present_o,
  output logic [CODE_W-1:0] opt_code_o,
  output logic [OFF_W-1:0]  value_offset_o,
  output logic [LEN_W-1:0]  value_length_o
);

  // The area length input cannot exceed its own field width.
  localparam int AreaClampInt = (MAX_AREA > (2 ** AREA_W) - 1) ? (2 ** AREA_W) - 1 : MAX_AREA;
  localparam logic [AREA_W-1:0] AREA_CLAMP = AREA_W'(AreaClampInt);

  logic [POS_W-1:0]  pos_q, pos_d;
  logic [POS_W-1:0]  hs_q, hs_d;
  parse_phase_e      phase_q, phase_d;
  logic [CODE_W-1:0] code_q, code_d;
  logic [AREA_W-1:0] alen_q, alen_d;
  logic              done_q, done_d;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;

  logic [ENTRY_W-1:0] table_mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0] rd_data_q;
  logic               rd_hit_q;
  logic [CODE_W-1:0]  rd_code_q;

  logic              out_valid_q;
  logic              kind_q, present_q;
  logic [CODE_W-1:0] ocode_q;
  logic [OFF_W-1:0]  ooff_q;
  logic [LEN_W-1:0]  olen_q;

  logic [POS_W-1:0]  pos_e, hs_e;
  parse_phase_e      phase_e_v;
  logic [CODE_W-1:0] code_e;
  logic [AREA_W-1:0] alen_e;
  logic              done_e;
  logic [POS_W:0]    voff;
  logic [POS_W:0]    room;
  logic [POS_W+1:0]  hs_sum;
  logic              hdr_ok;
  logic              store;

  // A first byte restarts the area before the byte itself is parsed.
  always_comb begin
    if (first_byte_i) begin
      pos_e = '0;
      hs_e = '0;
      phase_e_v = PH_CODE;
      code_e = '0;
      done_e = 1'b0;
      alen_e = (area_length_i > AREA_CLAMP) ? AREA_CLAMP : area_length_i;
    end else begin
      pos_e = pos_q;
      hs_e = hs_q;
      phase_e_v = phase_q;
      code_e = code_q;
      done_e = done_q;
      alen_e = alen_q;
    end
  end

  assign voff = {1'b0, hs_e} + (POS_W+1)'(HDR_LEN);
  assign hdr_ok = voff < (POS_W+1)'(alen_e);
  // In the length phase the value offset is below the area length, so this cannot wrap.
  assign room = (POS_W+1)'(alen_e) - voff;
  assign hs_sum = {1'b0, voff} + (POS_W+2)'(data_byte_i);
  assign store = !done_e && (phase_e_v == PH_LENGTH) && ((POS_W+1)'(data_byte_i) <= room);

  always_comb begin
    pos_d = pos_q;
    hs_d = hs_q;
    phase_d = phase_q;
    code_d = code_q;
    alen_d = alen_q;
    done_d = done_q;
    valid_d = valid_q;
    if (cmd_i.byte_step) begin
      hs_d = hs_e;
      phase_d = phase_e_v;
      code_d = code_e;
      alen_d = alen_e;
      done_d = done_e;
      if (first_byte_i) begin
        valid_d = '0;
      end
      if (!done_e) begin
        if (phase_e_v == PH_CODE) begin
          if ((pos_e == hs_e) && hdr_ok) begin
            code_d = data_byte_i;
            phase_d = PH_LENGTH;
          end
        end else begin
          if (store) begin
            valid_d[code_e] = 1'b1;
          end
          if (code_e == END_CODE) begin
            done_d = 1'b1;
          end
          hs_d = (hs_sum > (POS_W+2)'(POS_LIMIT)) ? POS_LIMIT : hs_sum[POS_W-1:0];
          phase_d = PH_CODE;
        end
      end
      pos_d = (pos_e == POS_LIMIT) ? pos_e : pos_e + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      hs_q <= '0;
      phase_q <= PH_CODE;
      code_q <= '0;
      alen_q <= '0;
      done_q <= 1'b0;
      valid_q <= '0;
    end else begin
      pos_q <= pos_d;
      hs_q <= hs_d;
      phase_q <= phase_d;
      code_q <= code_d;
      alen_q <= alen_d;
      done_q <= done_d;
      valid_q <= valid_d;
    end
  end

  // Record table: one write port for stored records, one registered read for lookups.
  always_ff @(posedge clk_i) begin
    if (cmd_i.byte_step && store) begin
      table_mem[code_e] <= {voff[OFF_W-1:0], data_byte_i};
    end
    if (cmd_i.lookup_issue) begin
      rd_data_q <= table_mem[query_code_i];
      rd_code_q <= query_code_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_hit_q <= 1'b0;
    end else if (cmd_i.lookup_issue) begin
      rd_hit_q <= valid_q[query_code_i];
    end
  end

  // Result register. The controller only loads it when it is empty or draining.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.lookup_finish || (cmd_i.byte_step && store)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup_finish) begin
      kind_q <= KIND_LOOKUP;
      present_q <= rd_hit_q;
      ocode_q <= rd_code_q;
      ooff_q <= rd_hit_q ? rd_data_q[ENTRY_W-1:LEN_W] : '0;
      olen_q <= rd_hit_q ? rd_data_q[LEN_W-1:0] : '0;
    end else if (cmd_i.byte_step && store) begin
      kind_q <= KIND_RECORD;
      present_q <= 1'b1;
      ocode_q <= code_e;
      ooff_q <= voff[OFF_W-1:0];
      olen_q <= data_byte_i;
    end
  end

  assign status_o.out_stall = out_valid_q && !out_ready_i;
  assign out_valid_o = out_valid_q;
  assign kind_o = kind_q;
  assign present_o = present_q;
  assign opt_code_o = ocode_q;
  assign value_offset_o = ooff_q;
  assign value_length_o = olen_q;

  a_record_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (kind_q == KIND_RECORD) |-> present_q)
    else $error("stored record result without present flag");

  a_absent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (kind_q == KIND_LOOKUP) && !present_q |-> (ooff_q == '0) && (olen_q == '0))
    else $error("absent lookup returned nonzero offset or length");

  a_lookup_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.lookup_issue |=> ##1 out_valid_q && (kind_q == KIND_LOOKUP))
    else $error("lookup did not produce an answer");

endmodule

// ===== rtl/dhcp_option_tlv_parser_core.sv =====
// Top level of the DHCP option TLV parser core.
// Instantiates dotp_ctrl and dotp_datapath; depends on dotp_pkg.
`timescale 1ns / 1ps

// An options-area byte (mode 0) is parsed when accepted, so a packet streams
// at one byte per cycle unless input is stalled; a stored record appears in
// the output register the cycle after its length byte. A lookup (mode 1) does
// a registered read of the 256-entry record table, then blocks input in its
// finish state. A result waiting in the output register stalls input until
// it is taken. The valid marks are flip-flops cleared at once by a first byte.
module dhcp_option_tlv_parser_core
  import dotp_pkg::*;
#(
  parameter int MAX_AREA = MAX_AREA_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              mode_i,
  input  logic [7:0]        data_byte_i,
  input  logic              first_byte_i,
  input  logic [AREA_W-1:0] area_length_i,
  input  logic [7:0]        query_code_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              kind_o,
  output logic              present_o,
  output logic [CODE_W-1:0] opt_code_o,
  output logic [OFF_W-1:0]  value_offset_o,
  output logic [LEN_W-1:0]  value_length_o
);

  dotp_cmd_t    cmd;
  dotp_status_t status;

  dotp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_i),
    .status_i   (status),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  dotp_datapath #(
    .MAX_AREA (MAX_AREA)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .data_byte_i    (data_byte_i),
    .first_byte_i   (first_byte_i),
    .area_length_i  (area_length_i),
    .query_code_i   (query_code_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .present_o      (present_o),
    .opt_code_o     (opt_code_o),
    .value_offset_o (value_offset_o),
    .value_length_o (value_length_o)
  );

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input ready while a result is stalled");

  a_lookup_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (mode_i == MODE_LOOKUP) |=> !in_ready_o)
    else $error("input ready during lookup read cycle");

endmodule
